/* src/hmblod_pkg.sv */
// Shared constants, codes and control types of the heightmap bilinear LOD sampler.
package hmblod_pkg;

    localparam int GRID_POINTS_DEF = 65;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam int ROW_W   = 7;
    localparam int SCALE_W = 24;
    localparam int LOD_W   = 3;
    localparam int FRAC_W  = 16;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [LOD_W-1:0]   MAX_LOD          = 3'd6;
    localparam logic [LOD_W-1:0]   DETAIL_LEVEL_RST = 3'd0;
    localparam logic [SCALE_W-1:0] GRID_SCALE_RST   = 24'd65536;
    localparam logic [WGT_W-1:0]   WEIGHT_ONE       = 17'h10000;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DETAIL_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SCALE   = 1'b1;

    typedef struct packed {
        logic       wr;
        logic       cap;
        logic       scale;
        logic       axis;
        logic       rd_en;
        logic [1:0] rd_corner;
        logic       mx_en;
        logic [1:0] mx_corner;
        logic       bl_en;
        logic       bl_first;
        logic       out_load;
    } ctrl_cmd_t;

endpackage

/* src/hmblod_ctrl.sv */
// Sequencing state machine of the heightmap bilinear LOD sampler.
module hmblod_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hmblod_pkg::ctrl_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_AXIS  = 4'd2;
    localparam logic [3:0] ST_RD0   = 4'd3;
    localparam logic [3:0] ST_RD1   = 4'd4;
    localparam logic [3:0] ST_RD2   = 4'd5;
    localparam logic [3:0] ST_RD3   = 4'd6;
    localparam logic [3:0] ST_MX3   = 4'd7;
    localparam logic [3:0] ST_BL0   = 4'd8;
    localparam logic [3:0] ST_BL1   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr     = accept && (command == hmblod_pkg::CMD_WRITE);
        cmd.cap    = accept && (command == hmblod_pkg::CMD_SAMPLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.cap)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_AXIS;
            end
            ST_AXIS:
            begin
                cmd.axis   = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_corner = 2'd0;
                state_next    = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_corner = 2'd1;
                cmd.mx_en     = 1'b1;
                cmd.mx_corner = 2'd0;
                state_next    = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_corner = 2'd2;
                cmd.mx_en     = 1'b1;
                cmd.mx_corner = 2'd1;
                state_next    = ST_RD3;
            end
            ST_RD3:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_corner = 2'd3;
                cmd.mx_en     = 1'b1;
                cmd.mx_corner = 2'd2;
                state_next    = ST_MX3;
            end
            ST_MX3:
            begin
                cmd.mx_en     = 1'b1;
                cmd.mx_corner = 2'd3;
                state_next    = ST_BL0;
            end
            ST_BL0:
            begin
                cmd.bl_en    = 1'b1;
                cmd.bl_first = 1'b1;
                state_next   = ST_BL1;
            end
            ST_BL1:
            begin
                cmd.bl_en  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/hmblod_datapath.sv */
// Configuration registers, height memory, grid mapping and blend arithmetic.
module hmblod_datapath
#(
    parameter int GRID_POINTS = hmblod_pkg::GRID_POINTS_DEF,
    parameter int HEIGHT_BITS = hmblod_pkg::HEIGHT_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hmblod_pkg::ctrl_cmd_t                cmd,
    input  logic                                 cfg_we,
    input  logic [hmblod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmblod_pkg::CFG_W-1:0]         cfg_data,
    input  logic [hmblod_pkg::ROW_W-1:0]         write_row,
    input  logic [hmblod_pkg::ROW_W-1:0]         write_col,
    input  logic [HEIGHT_BITS-1:0]               write_height,
    input  logic [hmblod_pkg::SCALE_W-1:0]       sample_x,
    input  logic [hmblod_pkg::SCALE_W-1:0]       sample_y,
    output logic [HEIGHT_BITS-1:0]               height
);

    localparam int DEPTH = GRID_POINTS * GRID_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_POINTS);
    localparam int NW    = CW + 8;
    localparam int PW    = CW + hmblod_pkg::FRAC_W;
    localparam int SW_IN = hmblod_pkg::SCALE_W;
    localparam int MW    = 2 * SW_IN;
    localparam int FW    = hmblod_pkg::FRAC_W;
    localparam int WW    = hmblod_pkg::WGT_W;
    localparam int AXW   = HEIGHT_BITS + FW;
    localparam int SUMW  = HEIGHT_BITS + 2 * FW;
    localparam logic [31:0] LIMIT = 32'(GRID_POINTS - 1) << FW;
    localparam logic [HEIGHT_BITS-1:0] SIGN_BIT = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

    logic [hmblod_pkg::LOD_W-1:0]   detail_level_reg;
    logic [hmblod_pkg::SCALE_W-1:0] grid_scale_reg;

    logic [HEIGHT_BITS-1:0] height_store [DEPTH];
    logic [HEIGHT_BITS-1:0] rd_data_reg;

    logic [SW_IN-1:0]       pos_reg   [2];
    logic [31:0]            p_reg     [2];
    logic [CW-1:0]          cell_reg  [2];
    logic [CW-1:0]          next_reg  [2];
    logic [FW-1:0]          frac_reg  [2];
    logic [CW-1:0]          cell_next [2];
    logic [CW-1:0]          near_next [2];
    logic [FW-1:0]          frac_next [2];

    logic [AXW-1:0]         a_reg;
    logic [AXW-1:0]         b_reg;
    logic [SUMW-1:0]        acc_reg;
    logic [HEIGHT_BITS-1:0] height_reg;

    logic [hmblod_pkg::LOD_W-1:0] lod;
    logic                   wr_ok;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          mem_addr;
    logic [CW-1:0]          rd_row;
    logic [CW-1:0]          rd_col;

    logic [WW-1:0]          wx0;
    logic [WW-1:0]          wx1;
    logic [WW-1:0]          wy0;
    logic [WW-1:0]          wy1;
    logic [HEIGHT_BITS-1:0] biased;
    logic [WW-1:0]          mx_w;
    logic [AXW:0]           mx_prod;
    logic [AXW-1:0]         mx_term;
    logic [AXW-1:0]         bl_src;
    logic [WW-1:0]          bl_w;
    logic [SUMW-1:0]        bl_prod;
    logic [SUMW-1:0]        rounded;

    assign lod = (detail_level_reg > hmblod_pkg::MAX_LOD) ? hmblod_pkg::MAX_LOD
                                                          : detail_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detail_level_reg <= hmblod_pkg::DETAIL_LEVEL_RST;
            grid_scale_reg   <= hmblod_pkg::GRID_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hmblod_pkg::CFG_DETAIL_LEVEL:
                begin
                    detail_level_reg <= cfg_data[hmblod_pkg::LOD_W-1:0];
                end
                hmblod_pkg::CFG_GRID_SCALE:
                begin
                    grid_scale_reg <= cfg_data[hmblod_pkg::SCALE_W-1:0];
                end
                default:
                begin
                    grid_scale_reg <= grid_scale_reg;
                end
            endcase
        end
    end

    // Single-port height memory: writes only while idle, reads only while busy.
    assign wr_ok   = (10'(write_row) < 10'(GRID_POINTS)) && (10'(write_col) < 10'(GRID_POINTS));
    assign wr_addr = AW'(write_row) * AW'(GRID_POINTS) + AW'(write_col);
    assign rd_row  = cmd.rd_corner[0] ? next_reg[0] : cell_reg[0];
    assign rd_col  = cmd.rd_corner[1] ? next_reg[1] : cell_reg[1];
    assign rd_addr = AW'(rd_row) * AW'(GRID_POINTS) + AW'(rd_col);
    assign mem_addr = cmd.wr ? wr_addr : rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_ok)
        begin
            height_store[mem_addr] <= write_height;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= height_store[mem_addr];
        end
    end

    always_comb
    begin
        logic [PW-1:0] pc;
        logic [CW-1:0] cell_raw;
        logic [CW-1:0] hi_mask;
        logic [PW-1:0] diff;
        logic [PW-1:0] shifted;
        logic [NW-1:0] nw;
        for (int i = 0; i < 2; i++)
        begin
            pc       = (p_reg[i] > LIMIT) ? PW'(LIMIT) : p_reg[i][PW-1:0];
            cell_raw = pc[PW-1:FW];
            hi_mask  = {CW{1'b1}} << lod;
            cell_next[i] = cell_raw & hi_mask;
            diff     = {cell_raw & ~hi_mask, pc[FW-1:0]};
            shifted  = diff >> lod;
            frac_next[i] = shifted[FW-1:0];
            nw = NW'(cell_next[i]) + (NW'(1) << lod);
            near_next[i] = (nw > NW'(GRID_POINTS - 1)) ? CW'(GRID_POINTS - 1) : nw[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [MW-1:0] prod;
        if (cmd.cap)
        begin
            pos_reg[0] <= sample_x;
            pos_reg[1] <= sample_y;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (cmd.scale)
            begin
                prod     = MW'(pos_reg[i]) * MW'(grid_scale_reg);
                p_reg[i] <= prod[MW-1:FW];
            end
            if (cmd.axis)
            begin
                cell_reg[i] <= cell_next[i];
                next_reg[i] <= near_next[i];
                frac_reg[i] <= frac_next[i];
            end
        end
    end

    assign wx1 = {1'b0, frac_reg[0]};
    assign wx0 = hmblod_pkg::WEIGHT_ONE - wx1;
    assign wy1 = {1'b0, frac_reg[1]};
    assign wy0 = hmblod_pkg::WEIGHT_ONE - wy1;

    // Blend along x into the two row pairs first, then along y.
    assign biased  = rd_data_reg ^ SIGN_BIT;
    assign mx_w    = cmd.mx_corner[0] ? wx1 : wx0;
    assign mx_prod = (AXW + 1)'(biased) * (AXW + 1)'(mx_w);
    assign mx_term = mx_prod[AXW-1:0];
    assign bl_src  = cmd.bl_first ? a_reg : b_reg;
    assign bl_w    = cmd.bl_first ? wy0 : wy1;
    assign bl_prod = SUMW'(bl_src) * SUMW'(bl_w);
    assign rounded = acc_reg + (SUMW'(1) << (2 * FW - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mx_en)
        begin
            if (!cmd.mx_corner[1])
            begin
                a_reg <= cmd.mx_corner[0] ? (a_reg + mx_term) : mx_term;
            end
            else
            begin
                b_reg <= cmd.mx_corner[0] ? (b_reg + mx_term) : mx_term;
            end
        end
        if (cmd.bl_en)
        begin
            acc_reg <= cmd.bl_first ? bl_prod : (acc_reg + bl_prod);
        end
        if (cmd.out_load)
        begin
            height_reg <= rounded[SUMW-1:2*FW] ^ SIGN_BIT;
        end
    end

    assign height = height_reg;

endmodule

/* src/heightmap_bilinear_lod_sample.sv */
// Top level of the heightmap bilinear LOD sampler.
// A write beat stores one height in a single-port memory of GRID_POINTS x GRID_POINTS
// entries; the block can accept the next beat on the following cycle.
// A sample beat occupies the block from acceptance until it returns to idle: the SCALE
// state scales the position by grid_scale, AXIS clamps and snaps it to the detail step,
// RD0 to RD3 read the four corners one after another from the single memory port while
// the x blend of each corner runs in the cycle after its read, MX3 finishes the x blend,
// BL0 and BL1 do the y blend, OUT loads the result register, and the next beat can be
// taken once the block is back in idle. The result is held until it is taken and does not
// stop new beats from being accepted; only the final load waits for a free result register.
// Entries that were never written read as arbitrary values.
module heightmap_bilinear_lod_sample
#(
    parameter int GRID_POINTS = hmblod_pkg::GRID_POINTS_DEF,
    parameter int HEIGHT_BITS = hmblod_pkg::HEIGHT_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hmblod_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmblod_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic [hmblod_pkg::ROW_W-1:0]         write_row,
    input  logic [hmblod_pkg::ROW_W-1:0]         write_col,
    input  logic signed [HEIGHT_BITS-1:0]        write_height,
    input  logic [hmblod_pkg::SCALE_W-1:0]       sample_x,
    input  logic [hmblod_pkg::SCALE_W-1:0]       sample_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [HEIGHT_BITS-1:0]        height
);

    hmblod_pkg::ctrl_cmd_t cmd;

    hmblod_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    hmblod_datapath
    #(
        .GRID_POINTS (GRID_POINTS),
        .HEIGHT_BITS (HEIGHT_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .write_row    (write_row),
        .write_col    (write_col),
        .write_height (write_height),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .height       (height)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("Result register loaded while a held result was stalled.");

    a_read_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (in_stall && !cmd.wr))
        else $error("Memory read overlaps an accepted beat.");

    a_blend_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bl_en && !cmd.bl_first) |-> $past(cmd.bl_en && cmd.bl_first))
        else $error("Second blend step without the first.");

    a_scale_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale |-> $past(cmd.cap))
        else $error("Scale step without a captured sample.");

endmodule
